// File: rtl/ehd_pkg.sv
package ehd_pkg;

    localparam int CHAR_W      = 8;
    localparam int NIBBLE_BITS = 4;
    localparam int MODE_W      = 2;

    localparam logic [CHAR_W-1:0] PCT_CHAR = 8'h25;

    localparam logic [MODE_W-1:0] MODE_RAW = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ESC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HEX = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ESC    = 2'd1,
        PH_ESC_HI = 2'd2,
        PH_HEX_HI = 2'd3
    } phase_t;

    typedef struct packed {
        logic [CHAR_W-1:0] data;
        logic              last;
        logic              truncated;
    } result_t;

    // non-hex characters decode as zero
    function automatic logic [NIBBLE_BITS-1:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [NIBBLE_BITS-1:0] v;
        v = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[NIBBLE_BITS-1:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = c[NIBBLE_BITS-1:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

// File: rtl/escape_or_hex_byte_decoder.sv
// Percent-escape / hex-pair byte decoder.
//
// Input channel (s_valid/s_ready): one encoded character per beat, s_in_last
// on the final character of a string. Output channel (m_valid/m_ready): one
// decoded byte per beat; m_out_last ends a decoded string, and m_truncated
// (with m_out_byte zero) marks a string that ended inside an unfinished pair.
// Characters that only open an escape or a hex pair give no output beat.
//
// cfg_wr_en/cfg_wr_data write the mode: 0 raw, 1 percent escape, 2 hex pairs,
// 3 acts as raw. Write it only while no string is in flight.
//
// Timing: an accepted beat is held in the input register, is decoded there and
// lands in the output register, which drives m_valid and holds the beat until
// it leaves. One character per cycle is sustained while the output is not
// stalled; the only loop is the phase/high-nibble update.
// When m_ready is low the output register holds its beat, the input register
// still takes one more character, and s_ready drops only while both are full.
// Reset clears both stage valids, the phase, the held nibble and the mode.
module escape_or_hex_byte_decoder (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [ehd_pkg::MODE_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ehd_pkg::CHAR_W-1:0]  s_in_char,
    input  logic                        s_in_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ehd_pkg::CHAR_W-1:0]  m_out_byte,
    output logic                        m_out_last,
    output logic                        m_truncated
);

    logic [ehd_pkg::MODE_W-1:0] mode_reg;
    logic                       hold_valid;
    logic [ehd_pkg::CHAR_W-1:0] hold_char;
    logic                       hold_last;
    logic                       can_take;
    logic                       advance;
    logic                       emit;
    ehd_pkg::result_t           result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ehd_pkg::MODE_RAW;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    assign advance = hold_valid && can_take;

    ehd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_char  (s_in_char),
        .s_in_last  (s_in_last),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_char  (hold_char),
        .hold_last  (hold_last)
    );

    ehd_decode u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mode    (mode_reg),
        .step    (advance),
        .in_char (hold_char),
        .in_last (hold_last),
        .emit    (emit),
        .result  (result)
    );

    ehd_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance && emit),
        .result      (result),
        .can_take    (can_take),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_last  (m_out_last),
        .m_truncated (m_truncated)
    );

endmodule

// File: rtl/ehd_in_stage.sv
module ehd_in_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ehd_pkg::CHAR_W-1:0]  s_in_char,
    input  logic                        s_in_last,
    input  logic                        advance,
    output logic                        hold_valid,
    output logic [ehd_pkg::CHAR_W-1:0]  hold_char,
    output logic                        hold_last
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [ehd_pkg::CHAR_W-1:0] char_reg;
    logic                       last_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_valid || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_in_char;
            last_reg <= s_in_last;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_char  = char_reg;
    assign hold_last  = last_reg;

endmodule

// File: rtl/ehd_decode.sv
module ehd_decode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ehd_pkg::MODE_W-1:0]    mode,
    input  logic                          step,
    input  logic [ehd_pkg::CHAR_W-1:0]    in_char,
    input  logic                          in_last,
    output logic                          emit,
    output ehd_pkg::result_t              result
);

    ehd_pkg::phase_t                    phase_reg;
    ehd_pkg::phase_t                    phase_next;
    logic [ehd_pkg::NIBBLE_BITS-1:0]    nibble_reg;
    logic [ehd_pkg::NIBBLE_BITS-1:0]    nibble_next;
    logic [ehd_pkg::NIBBLE_BITS-1:0]    digit;
    logic                               is_pct;

    assign digit  = ehd_pkg::hex_value(in_char);
    assign is_pct = (in_char == ehd_pkg::PCT_CHAR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= ehd_pkg::PH_IDLE;
            nibble_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            nibble_reg <= nibble_next;
        end
    end

    // next state; a phase foreign to the current mode counts as idle
    always_comb begin
        phase_next  = phase_reg;
        nibble_next = nibble_reg;
        if (step) begin
            case (mode)
                ehd_pkg::MODE_ESC: begin
                    if (phase_reg == ehd_pkg::PH_ESC) begin
                        if (is_pct) begin
                            phase_next = ehd_pkg::PH_IDLE;
                        end else begin
                            nibble_next = digit;
                            phase_next  = in_last ? ehd_pkg::PH_IDLE : ehd_pkg::PH_ESC_HI;
                        end
                    end else if (phase_reg == ehd_pkg::PH_ESC_HI) begin
                        phase_next = ehd_pkg::PH_IDLE;
                    end else begin
                        phase_next = (is_pct && !in_last) ? ehd_pkg::PH_ESC : ehd_pkg::PH_IDLE;
                    end
                end
                ehd_pkg::MODE_HEX: begin
                    if (phase_reg == ehd_pkg::PH_HEX_HI) begin
                        phase_next = ehd_pkg::PH_IDLE;
                    end else begin
                        nibble_next = digit;
                        phase_next  = in_last ? ehd_pkg::PH_IDLE : ehd_pkg::PH_HEX_HI;
                    end
                end
                default: begin
                    phase_next = ehd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // result for the beat at the input stage
    always_comb begin
        emit             = 1'b0;
        result.data      = in_char;
        result.last      = in_last;
        result.truncated = 1'b0;
        case (mode)
            ehd_pkg::MODE_ESC: begin
                if (phase_reg == ehd_pkg::PH_ESC) begin
                    if (is_pct) begin
                        emit = 1'b1;
                    end else if (in_last) begin
                        emit             = 1'b1;
                        result.data      = '0;
                        result.truncated = 1'b1;
                    end
                end else if (phase_reg == ehd_pkg::PH_ESC_HI) begin
                    emit        = 1'b1;
                    result.data = {nibble_reg, digit};
                end else begin
                    if (!is_pct) begin
                        emit = 1'b1;
                    end else if (in_last) begin
                        emit             = 1'b1;
                        result.data      = '0;
                        result.truncated = 1'b1;
                    end
                end
            end
            ehd_pkg::MODE_HEX: begin
                if (phase_reg == ehd_pkg::PH_HEX_HI) begin
                    emit        = 1'b1;
                    result.data = {nibble_reg, digit};
                end else if (in_last) begin
                    emit             = 1'b1;
                    result.data      = '0;
                    result.truncated = 1'b1;
                end
            end
            default: begin
                emit = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/ehd_out_stage.sv
module ehd_out_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  ehd_pkg::result_t            result,
    output logic                        can_take,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ehd_pkg::CHAR_W-1:0]  m_out_byte,
    output logic                        m_out_last,
    output logic                        m_truncated
);

    logic             valid_reg;
    logic             valid_next;
    ehd_pkg::result_t data_reg;

    assign can_take   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid     = valid_reg;
    assign m_out_byte  = data_reg.data;
    assign m_out_last  = data_reg.last;
    assign m_truncated = data_reg.truncated;

endmodule

// File: rtl/ehd_checker.sv
module ehd_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [ehd_pkg::CHAR_W-1:0]  m_out_byte,
    input logic                        m_out_last,
    input logic                        m_truncated
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_out_last) && $stable(m_truncated))
        else $error("output beat changed while stalled");

    // truncation always closes a string with a zero byte
    a_trunc_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_truncated |-> m_out_last && m_out_byte == '0)
        else $error("truncated beat without last or with nonzero byte");

    // input backpressure only when the output side is full and stalled
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with output free");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind escape_or_hex_byte_decoder ehd_checker u_ehd_checker (.*);

// File: tb/sv/ehd_checker.sv
module ehd_scoreboard (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [ehd_pkg::MODE_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [ehd_pkg::CHAR_W-1:0]  s_in_char,
    input  logic                        s_in_last,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [ehd_pkg::CHAR_W-1:0]  m_out_byte,
    input  logic                        m_out_last,
    input  logic                        m_truncated,
    output int                          mismatches,
    output int                          pending,
    output int                          results_seen
);

    localparam int REPORT_MAX = 10;

    ehd_pkg::result_t                     decoded_q[$];
    logic [ehd_pkg::MODE_W-1:0]           cur_mode;
    ehd_pkg::phase_t                      cur_phase;
    logic [ehd_pkg::NIBBLE_BITS-1:0]      held_nib;
    int                                   n_bad;
    int                                   n_seen;

    initial begin
        mismatches   = 0;
        pending      = 0;
        results_seen = 0;
        n_bad        = 0;
        n_seen       = 0;
        cur_mode     = ehd_pkg::MODE_RAW;
        cur_phase    = ehd_pkg::PH_IDLE;
        held_nib     = '0;
    end

    // anything that is not a hex digit reads as zero
    function automatic logic [ehd_pkg::NIBBLE_BITS-1:0] digit_val(
        input logic [ehd_pkg::CHAR_W-1:0] c);
        logic [ehd_pkg::CHAR_W-1:0] v;
        v = '0;
        if (c >= "0" && c <= "9") begin
            v = c - "0";
        end else if (c >= "A" && c <= "F") begin
            v = c - "A" + 8'd10;
        end else if (c >= "a" && c <= "f") begin
            v = c - "a" + 8'd10;
        end
        return v[ehd_pkg::NIBBLE_BITS-1:0];
    endfunction

    // advances the decode state by one character; returns 1 when a byte comes out
    function automatic bit decode_char(input logic [ehd_pkg::CHAR_W-1:0] c,
                                       input logic fin,
                                       output ehd_pkg::result_t r);
        r = '0;
        if (cur_mode == ehd_pkg::MODE_ESC) begin
            if (cur_phase == ehd_pkg::PH_ESC) begin
                if (c == ehd_pkg::PCT_CHAR) begin
                    cur_phase = ehd_pkg::PH_IDLE;
                    r = {ehd_pkg::PCT_CHAR, fin, 1'b0};
                    return 1'b1;
                end
                held_nib = digit_val(c);
                if (fin) begin
                    cur_phase = ehd_pkg::PH_IDLE;
                    r = {8'h00, 1'b1, 1'b1};
                    return 1'b1;
                end
                cur_phase = ehd_pkg::PH_ESC_HI;
                return 1'b0;
            end
            if (cur_phase == ehd_pkg::PH_ESC_HI) begin
                cur_phase = ehd_pkg::PH_IDLE;
                r = {held_nib, digit_val(c), fin, 1'b0};
                return 1'b1;
            end
            // idle, or a phase stranded by a mode change
            cur_phase = ehd_pkg::PH_IDLE;
            if (c != ehd_pkg::PCT_CHAR) begin
                r = {c, fin, 1'b0};
                return 1'b1;
            end
            if (fin) begin
                r = {8'h00, 1'b1, 1'b1};
                return 1'b1;
            end
            cur_phase = ehd_pkg::PH_ESC;
            return 1'b0;
        end
        if (cur_mode == ehd_pkg::MODE_HEX) begin
            if (cur_phase == ehd_pkg::PH_HEX_HI) begin
                cur_phase = ehd_pkg::PH_IDLE;
                r = {held_nib, digit_val(c), fin, 1'b0};
                return 1'b1;
            end
            held_nib = digit_val(c);
            if (fin) begin
                cur_phase = ehd_pkg::PH_IDLE;
                r = {8'h00, 1'b1, 1'b1};
                return 1'b1;
            end
            cur_phase = ehd_pkg::PH_HEX_HI;
            return 1'b0;
        end
        // raw, and the spare mode code
        cur_phase = ehd_pkg::PH_IDLE;
        r = {c, fin, 1'b0};
        return 1'b1;
    endfunction

    always @(posedge aclk) begin : watch
        ehd_pkg::result_t got;
        ehd_pkg::result_t want;
        if (!aresetn) begin
            decoded_q.delete();
            cur_mode  = ehd_pkg::MODE_RAW;
            cur_phase = ehd_pkg::PH_IDLE;
            held_nib  = '0;
        end else begin
            if (cfg_wr_en) begin
                cur_mode = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                if (decode_char(s_in_char, s_in_last, got)) begin
                    decoded_q.push_back(got);
                end
            end
            if (m_valid && m_ready) begin
                n_seen++;
                if (decoded_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= REPORT_MAX) begin
                        $display("unexpected output beat: byte %02h last %0b trunc %0b",
                                 m_out_byte, m_out_last, m_truncated);
                    end
                end else begin
                    want = decoded_q.pop_front();
                    if (m_out_byte !== want.data || m_out_last !== want.last ||
                        m_truncated !== want.truncated) begin
                        n_bad++;
                        if (n_bad <= REPORT_MAX) begin
                            $display("mismatch: expected byte %02h last %0b trunc %0b,",
                                     want.data, want.last, want.truncated);
                            $display("          got byte %02h last %0b trunc %0b",
                                     m_out_byte, m_out_last, m_truncated);
                        end
                    end
                end
            end
        end
        mismatches   <= n_bad;
        pending      <= decoded_q.size();
        results_seen <= n_seen;
    end

endmodule

// File: tb/sv/tb_escape_or_hex_byte_decoder.sv
module tb_escape_or_hex_byte_decoder;

    typedef logic [ehd_pkg::CHAR_W-1:0] char_t;
    typedef logic [ehd_pkg::MODE_W-1:0] mode_val_t;

    localparam mode_val_t MODE_SPARE = 2'd3;
    localparam int ITEMS_TARGET  = 2000;
    localparam int SETTLE_CYCLES = 6;

    typedef char_t char_q_t[$];

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    mode_val_t   cfg_wr_data = '0;
    logic        s_valid     = 1'b0;
    char_t       s_in_char   = '0;
    logic        s_in_last   = 1'b0;
    logic        m_ready     = 1'b0;
    logic        s_ready;
    logic        m_valid;
    char_t       m_out_byte;
    logic        m_out_last;
    logic        m_truncated;

    int mismatches;
    int pending;
    int results_seen;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int sent     = 0;
    int mode_uses[4];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    escape_or_hex_byte_decoder dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_char   (s_in_char),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_last  (m_out_last),
        .m_truncated (m_truncated)
    );

    ehd_scoreboard u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_char    (s_in_char),
        .s_in_last    (s_in_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_out_last   (m_out_last),
        .m_truncated  (m_truncated),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // hex digit in either case, now and then a stray byte
    function automatic char_t hex_char();
        int r;
        if ($urandom_range(0, 9) == 0) begin
            return char_t'($urandom_range(0, 255));
        end
        r = $urandom_range(0, 21);
        if (r < 10) begin
            return char_t'("0" + r);
        end
        if (r < 16) begin
            return char_t'("A" + r - 10);
        end
        return char_t'("a" + r - 16);
    endfunction

    task automatic send_beat(input char_t c, input logic fin);
        int g;
        g = pick_gap(tx_quiet);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_char <= c;
        s_in_last <= fin;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic send_string(input char_q_t chars);
        for (int i = 0; i < chars.size(); i++) begin
            send_beat(chars[i], i == chars.size() - 1);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // only once the pipe is empty; characters that open a pair leave no beat,
    // so wait SETTLE_CYCLES longer after the last result
    task automatic set_mode(input mode_val_t m);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mode_uses[m]++;
    endtask

    initial begin : rx_side
        int g;
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            g = pick_gap(rx_quiet);
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        char_q_t   q;
        mode_val_t m;
        char_t     b;
        int        budget;
        int        n;
        int        r;
        int        phase_no;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // raw mode straight out of reset
        q = '{8'h00, 8'hFF, ehd_pkg::PCT_CHAR};
        send_string(q);

        set_mode(ehd_pkg::MODE_ESC);
        q = '{"a", ehd_pkg::PCT_CHAR, ehd_pkg::PCT_CHAR, ehd_pkg::PCT_CHAR, "4", "f",
              ehd_pkg::PCT_CHAR, "g", "z"};
        send_string(q);
        q = '{ehd_pkg::PCT_CHAR};              // string ends right on the escape
        send_string(q);
        q = '{ehd_pkg::PCT_CHAR, "7"};         // ends after the high digit
        send_string(q);
        q = '{ehd_pkg::PCT_CHAR, "0", "9"};
        send_string(q);

        set_mode(ehd_pkg::MODE_HEX);
        q = '{"A", "f", "9", "0"};
        send_string(q);
        q = '{"x"};                            // odd count, pair left open
        send_string(q);

        set_mode(MODE_SPARE);
        q = '{8'h80, 8'h7F};
        send_string(q);

        phase_no = 0;
        while (sent < ITEMS_TARGET) begin
            if (phase_no < 4) begin
                m = mode_val_t'(phase_no);
            end else begin
                r = $urandom_range(0, 9);
                m = (r < 2) ? ehd_pkg::MODE_RAW : (r < 5) ? ehd_pkg::MODE_ESC :
                    (r < 8) ? ehd_pkg::MODE_HEX : (r < 9) ? MODE_SPARE : ehd_pkg::MODE_RAW;
            end
            phase_no++;
            set_mode(m);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            budget   = sent + $urandom_range(80, 250);

            while (sent < budget) begin
                if ($urandom_range(0, 49) == 0) begin
                    drain();
                end
                q.delete();
                case (m)
                    ehd_pkg::MODE_ESC: begin
                        n = $urandom_range(1, 8);
                        for (int k = 0; k < n; k++) begin
                            r = $urandom_range(0, 99);
                            if (r < 45) begin
                                b = char_t'($urandom_range(0, 255));
                                q.push_back(b);
                                if (b == ehd_pkg::PCT_CHAR) begin
                                    q.push_back(ehd_pkg::PCT_CHAR);
                                end
                            end else if (r < 60) begin
                                q.push_back(ehd_pkg::PCT_CHAR);
                                q.push_back(ehd_pkg::PCT_CHAR);
                            end else begin
                                q.push_back(ehd_pkg::PCT_CHAR);
                                q.push_back(hex_char());
                                q.push_back(hex_char());
                            end
                        end
                        if ($urandom_range(0, 99) < 12) begin
                            q.push_back(ehd_pkg::PCT_CHAR);
                            if ($urandom_range(0, 1) == 1) begin
                                q.push_back(hex_char());
                            end
                        end
                    end
                    ehd_pkg::MODE_HEX: begin
                        n = $urandom_range(1, 8);
                        for (int k = 0; k < 2 * n; k++) begin
                            q.push_back(hex_char());
                        end
                        if ($urandom_range(0, 99) < 15) begin
                            q.push_back(hex_char());
                        end
                    end
                    default: begin
                        n = $urandom_range(1, 12);
                        for (int k = 0; k < n; k++) begin
                            q.push_back(char_t'($urandom_range(0, 255)));
                        end
                    end
                endcase
                send_string(q);
            end

            // sometimes leave a pair open across the next mode change
            if ((m == ehd_pkg::MODE_ESC || m == ehd_pkg::MODE_HEX) &&
                $urandom_range(0, 3) == 0) begin
                if (m == ehd_pkg::MODE_ESC) begin
                    send_beat(ehd_pkg::PCT_CHAR, 1'b0);
                    if ($urandom_range(0, 1) == 1) begin
                        send_beat(hex_char(), 1'b0);
                    end
                end else begin
                    send_beat(hex_char(), 1'b0);
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("sent %0d characters over %0d mode settings, %0d output beats checked",
                 sent, phase_no + 3, results_seen);
        $display("settings used: raw %0d, escape %0d, hex %0d, spare code %0d",
                 mode_uses[ehd_pkg::MODE_RAW], mode_uses[ehd_pkg::MODE_ESC],
                 mode_uses[ehd_pkg::MODE_HEX], mode_uses[MODE_SPARE]);
        if (mismatches == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #2_500_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: escape_or_hex_byte_decoder.f
rtl/ehd_pkg.sv
rtl/ehd_in_stage.sv
rtl/ehd_decode.sv
rtl/ehd_out_stage.sv
rtl/escape_or_hex_byte_decoder.sv
rtl/ehd_checker.sv
tb/sv/ehd_checker.sv
tb/sv/tb_escape_or_hex_byte_decoder.sv
